// ===== design/itst_pkg.sv =====
package itst_pkg;

  localparam int SLOTS    = 32;
  localparam int TAG_BITS = 16;

  localparam int TagInW   = 16;
  localparam int TagW     = (TAG_BITS < TagInW) ? TAG_BITS : TagInW;
  localparam int SlotIdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CountW   = $clog2(SLOTS + 1);
  localparam int SlotOutW = 5;

  localparam logic [31:0] ALL_ONES32 = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DISABLED  = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_UNPAIRED  = 3'd4
  } status_e;

  typedef enum logic {
    OP_BEGIN = 1'b0,
    OP_END   = 1'b1
  } op_e;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } fsm_e;

  typedef struct packed {
    logic        open;
    logic [31:0] open_time;
    logic [31:0] first_begin;
    logic [31:0] last_finish;
    logic [31:0] count_begins;
    logic [31:0] count_unpaired;
    logic [31:0] shortest;
    logic [31:0] longest;
    logic [63:0] sum_elapsed;
  } stat_rec_t;

  localparam stat_rec_t RESET_REC = '{
    open:           1'b0,
    open_time:      32'd0,
    first_begin:    32'd0,
    last_finish:    32'd0,
    count_begins:   32'd0,
    count_unpaired: 32'd0,
    shortest:       ALL_ONES32,
    longest:        32'd0,
    sum_elapsed:    64'd0
  };

  typedef struct packed {
    logic                hit;
    logic [SlotIdxW-1:0] idx;
    logic [SlotIdxW-1:0] free_idx;
    logic                full;
  } lookup_t;

  typedef struct packed {
    status_e               status;
    logic [SlotOutW-1:0]   slot;
    logic [31:0]           elapsed;
    logic [63:0]           total_time;
    logic [31:0]           begin_count;
    logic [31:0]           min_time;
    logic [31:0]           max_time;
    logic [31:0]           unpaired_count;
    logic [31:0]           start_offset;
    logic [31:0]           end_offset;
  } result_t;

endpackage

// ===== design/itst_if.sv =====
interface itst_in_if import itst_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [TagInW-1:0] tag;
  logic [31:0]       timestamp;

  modport source (output valid, opcode, tag, timestamp, input ready);
  modport sink   (input valid, opcode, tag, timestamp, output ready);
endinterface

interface itst_out_if import itst_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [2:0]          status;
  logic [SlotOutW-1:0] slot;
  logic [31:0]         elapsed;
  logic [63:0]         total_time;
  logic [31:0]         begin_count;
  logic [31:0]         min_time;
  logic [31:0]         max_time;
  logic [31:0]         unpaired_count;
  logic [31:0]         start_offset;
  logic [31:0]         end_offset;

  modport source (output valid, status, slot, elapsed, total_time, begin_count, min_time,
                  max_time, unpaired_count, start_offset, end_offset, input ready);
  modport sink   (input valid, status, slot, elapsed, total_time, begin_count, min_time,
                  max_time, unpaired_count, start_offset, end_offset, output ready);
endinterface

// ===== design/itst_ram.sv =====
module itst_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                                           clk_i,
  input  logic                                           we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0]   waddr_i,
  input  logic [Width-1:0]                               wdata_i,
  input  logic                                           re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0]   raddr_i,
  output logic [Width-1:0]                               rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ===== design/itst_tag_cam.sv =====
module itst_tag_cam import itst_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [TagW-1:0] lookup_tag_i,
  input  logic            alloc_i,
  input  logic [TagW-1:0] alloc_tag_i,
  output lookup_t         lookup_o
);
  logic [TagW-1:0]   tag_q [SLOTS];
  logic [CountW-1:0] used_q;
  logic [CountW-1:0] used_d;

  always_comb begin
    lookup_o.hit      = 1'b0;
    lookup_o.idx      = '0;
    lookup_o.free_idx = used_q[SlotIdxW-1:0];
    lookup_o.full     = (used_q == CountW'(SLOTS));
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if ((CountW'(i) < used_q) && (tag_q[i] == lookup_tag_i)) begin
        lookup_o.hit = 1'b1;
        lookup_o.idx = SlotIdxW'(i);
      end
    end
  end

  assign used_d = alloc_i ? used_q + CountW'(1) : used_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else begin
      used_q <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (alloc_i) begin
      tag_q[used_q[SlotIdxW-1:0]] <= alloc_tag_i;
    end
  end
endmodule

// ===== design/interval_timing_stats_table_core.sv =====
// An accepted transaction is registered with its slot read, then its result goes
// to the output register. One transaction at a time: tag lookup and slot read,
// then the read-modify-write of the slot record in the single statistics RAM.
// A stalled output holds the block in its update cycle until the result is taken.
// Reset: asynchronous, active low; clears enable, slot count, earliest start and
// control; slot records need no clearing since new slots start from reset values.
module interval_timing_stats_table_core import itst_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  itst_in_if.sink    in_i,
  itst_out_if.source out_o
);
  fsm_e state_q, state_d;

  logic                enable_q;
  op_e                 op_q;
  logic [TagW-1:0]     tag_q;
  logic [31:0]         ts_q;
  logic                hit_q;
  logic                full_q;
  logic [SlotIdxW-1:0] addr_q;
  logic [31:0]         earliest_q, earliest_d;
  logic                out_valid_q;
  result_t             out_q, out_d;

  lookup_t             lk;
  logic                accept;
  logic                advance;
  logic                ram_we;
  logic                alloc;
  logic [TagW-1:0]     in_tag;
  stat_rec_t           rd_rec;
  stat_rec_t           cur, upd;
  logic [31:0]         el;
  logic [SlotIdxW+SlotOutW-1:0] slot_ext;

  assign in_tag = in_i.tag[TagW-1:0];
  assign accept = in_i.valid && in_i.ready;
  assign advance = (state_q == S_EXEC) && (!out_valid_q || out_o.ready);

  itst_tag_cam u_cam (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .lookup_tag_i (in_tag),
    .alloc_i      (advance && alloc),
    .alloc_tag_i  (tag_q),
    .lookup_o     (lk)
  );

  itst_ram #(
    .Width ($bits(stat_rec_t)),
    .Depth (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (upd),
    .re_i    (accept),
    .raddr_i (lk.hit ? lk.idx : lk.free_idx),
    .rdata_o (rd_rec)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (advance) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_i.ready = (state_q == S_IDLE);

  always_comb begin
    logic wr;
    wr         = 1'b0;
    alloc      = 1'b0;
    cur        = hit_q ? rd_rec : RESET_REC;
    upd        = cur;
    earliest_d = earliest_q;
    el         = ts_q - cur.open_time;
    out_d      = '0;
    out_d.status = ST_OK;
    if (!enable_q) begin
      out_d.status = ST_DISABLED;
    end else if (op_q == OP_BEGIN) begin
      if (!hit_q && full_q) begin
        out_d.status = ST_FULL;
      end else if (cur.open) begin
        wr = 1'b1;
        upd.count_unpaired = cur.count_unpaired + 32'd1;
        out_d.status = ST_UNPAIRED;
      end else begin
        wr    = 1'b1;
        alloc = !hit_q;
        upd.open_time = ts_q;
        upd.open      = 1'b1;
        if (cur.first_begin == 32'd0) begin
          upd.first_begin = ts_q;
          if (earliest_q > ts_q) begin
            earliest_d = ts_q;
          end
        end
        upd.count_begins = cur.count_begins + 32'd1;
      end
    end else begin
      if (!hit_q) begin
        out_d.status = ST_NOT_FOUND;
      end else if (!cur.open) begin
        wr = 1'b1;
        upd.count_unpaired = cur.count_unpaired + 32'd1;
        out_d.status = ST_UNPAIRED;
      end else begin
        wr = 1'b1;
        upd.last_finish = ts_q;
        upd.open        = 1'b0;
        upd.sum_elapsed = cur.sum_elapsed + {32'd0, el};
        if (el > cur.longest) begin
          upd.longest = el;
        end
        if (el < cur.shortest) begin
          upd.shortest = el;
        end
        out_d.elapsed = el;
      end
    end
    if (wr) begin
      slot_ext             = {{SlotOutW{1'b0}}, addr_q};
      out_d.slot           = slot_ext[SlotOutW-1:0];
      out_d.total_time     = upd.sum_elapsed;
      out_d.begin_count    = upd.count_begins;
      out_d.min_time       = upd.shortest;
      out_d.max_time       = upd.longest;
      out_d.unpaired_count = upd.count_unpaired;
      out_d.start_offset   = upd.first_begin - earliest_d;
      out_d.end_offset     = upd.last_finish - earliest_d;
    end else begin
      slot_ext = '0;
    end
    ram_we = advance && wr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      enable_q    <= 1'b0;
      earliest_q  <= ALL_ONES32;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        enable_q <= cfg_wdata_i;
      end
      if (advance) begin
        earliest_q  <= earliest_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= op_e'(in_i.opcode);
      tag_q  <= in_tag;
      ts_q   <= in_i.timestamp;
      hit_q  <= lk.hit;
      full_q <= lk.full;
      addr_q <= lk.hit ? lk.idx : lk.free_idx;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.status         = out_q.status;
  assign out_o.slot           = out_q.slot;
  assign out_o.elapsed        = out_q.elapsed;
  assign out_o.total_time     = out_q.total_time;
  assign out_o.begin_count    = out_q.begin_count;
  assign out_o.min_time       = out_q.min_time;
  assign out_o.max_time       = out_q.max_time;
  assign out_o.unpaired_count = out_q.unpaired_count;
  assign out_o.start_offset   = out_q.start_offset;
  assign out_o.end_offset     = out_q.end_offset;
endmodule

// ===== design/itst_checker.sv =====
module itst_checker import itst_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [2:0]          status_i,
  input logic [SlotOutW-1:0] slot_i,
  input logic [63:0]         total_time_i,
  input logic [31:0]         begin_count_i
);
  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("input accepted again while a transaction is in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (status_i == ST_OK || status_i == ST_DISABLED || status_i == ST_FULL ||
                     status_i == ST_NOT_FOUND || status_i == ST_UNPAIRED))
    else $error("undefined status code");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == ST_DISABLED || status_i == ST_FULL ||
                    status_i == ST_NOT_FOUND)
    |-> (slot_i == '0 && total_time_i == '0 && begin_count_i == '0))
    else $error("refused transaction carries slot statistics");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) && $stable(slot_i))
    else $error("stalled result changed");
endmodule

bind interval_timing_stats_table_core itst_checker u_itst_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .status_i      (out_o.status),
  .slot_i        (out_o.slot),
  .total_time_i  (out_o.total_time),
  .begin_count_i (out_o.begin_count)
);

// ===== tb/tb_interval_timing_stats_table_core.sv =====
`timescale 1ns / 1ps

module tb_interval_timing_stats_table_core;
  import itst_pkg::*;

  class interval_stats_scoreboard;
    logic              enable;
    logic [TagW-1:0]   slot_key [SLOTS];
    int unsigned       slots_used;
    stat_rec_t         rec [SLOTS];
    logic [31:0]       earliest;
    result_t           pending [$];
    int unsigned       mismatches;
    int unsigned       results_seen;
    int unsigned       status_seen [8];

    function new();
      enable       = 1'b0;
      slots_used   = 0;
      earliest     = ALL_ONES32;
      mismatches   = 0;
      results_seen = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_key[i] = '0;
        clear_slot(i);
      end
    endfunction

    function void clear_slot(int unsigned s);
      rec[s].open           = 1'b0;
      rec[s].open_time      = '0;
      rec[s].first_begin    = '0;
      rec[s].last_finish    = '0;
      rec[s].count_begins   = '0;
      rec[s].count_unpaired = '0;
      rec[s].shortest       = ALL_ONES32;
      rec[s].longest        = '0;
      rec[s].sum_elapsed    = '0;
    endfunction

    function int find_slot(logic [15:0] tag);
      int hit;
      hit = -1;
      for (int i = 0; i < slots_used; i++) begin
        if (hit < 0 && slot_key[i] == tag[TagW-1:0]) hit = i;
      end
      return hit;
    endfunction

    function bit tag_open(logic [15:0] tag);
      int hit;
      hit = find_slot(tag);
      return (hit >= 0) && rec[hit].open;
    endfunction

    function result_t predict_event(op_e op, logic [15:0] tag, logic [31:0] ts);
      result_t     r;
      int          hit;
      int unsigned s;
      logic [31:0] el;
      r = '0;
      if (!enable) begin
        r.status = ST_DISABLED;
        return r;
      end
      hit = find_slot(tag);
      if (op == OP_BEGIN) begin
        if (hit < 0) begin
          if (slots_used >= SLOTS) begin
            r.status = ST_FULL;
            return r;
          end
          s = slots_used;
          slot_key[s] = tag[TagW-1:0];
          clear_slot(s);
          slots_used++;
        end else begin
          s = hit;
        end
        if (rec[s].open) begin
          rec[s].count_unpaired = rec[s].count_unpaired + 1;
          r.status = ST_UNPAIRED;
        end else begin
          rec[s].open_time = ts;
          rec[s].open      = 1'b1;
          if (rec[s].first_begin == 0) begin
            rec[s].first_begin = ts;
            if (earliest > ts) earliest = ts;
          end
          rec[s].count_begins = rec[s].count_begins + 1;
          r.status = ST_OK;
        end
      end else begin
        if (hit < 0) begin
          r.status = ST_NOT_FOUND;
          return r;
        end
        s = hit;
        if (!rec[s].open) begin
          rec[s].count_unpaired = rec[s].count_unpaired + 1;
          r.status = ST_UNPAIRED;
        end else begin
          rec[s].last_finish = ts;
          el = ts - rec[s].open_time;
          if (el > rec[s].longest) rec[s].longest = el;
          if (el < rec[s].shortest) rec[s].shortest = el;
          rec[s].sum_elapsed = rec[s].sum_elapsed + 64'(el);
          rec[s].open = 1'b0;
          r.elapsed = el;
          r.status = ST_OK;
        end
      end
      r.slot           = SlotOutW'(s);
      r.total_time     = rec[s].sum_elapsed;
      r.begin_count    = rec[s].count_begins;
      r.min_time       = rec[s].shortest;
      r.max_time       = rec[s].longest;
      r.unpaired_count = rec[s].count_unpaired;
      r.start_offset   = rec[s].first_begin - earliest;
      r.end_offset     = rec[s].last_finish - earliest;
      return r;
    endfunction

    function void note_event(op_e op, logic [15:0] tag, logic [31:0] ts);
      result_t r;
      r = predict_event(op, tag, ts);
      status_seen[r.status]++;
      pending.push_back(r);
    endfunction

    function void report_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) $display("  %s: expected %0h, got %0h", name, want, got);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with no pending transaction, status %0h slot %0h",
                   $time, got.status, got.slot);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: mismatch on result %0d", $time, results_seen);
          report_field("status", want.status, got.status);
          report_field("slot", want.slot, got.slot);
          report_field("elapsed", want.elapsed, got.elapsed);
          report_field("total_time", want.total_time, got.total_time);
          report_field("begin_count", want.begin_count, got.begin_count);
          report_field("min_time", want.min_time, got.min_time);
          report_field("max_time", want.max_time, got.max_time);
          report_field("unpaired_count", want.unpaired_count, got.unpaired_count);
          report_field("start_offset", want.start_offset, got.start_offset);
          report_field("end_offset", want.end_offset, got.end_offset);
        end
      end
      results_seen++;
    endfunction

    function void close_out();
      if (pending.size() != 0) begin
        $display("%0d expected results never arrived", pending.size());
        mismatches += pending.size();
      end
    endfunction
  endclass

  localparam int POOL = 40;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic cfg_we_i    = 1'b0;
  logic cfg_wdata_i = 1'b0;

  int          idle_pct  = 0;
  int          stall_pct = 0;
  logic [31:0] tick;
  logic [15:0] tag_pool [POOL];

  interval_stats_scoreboard sb = new();

  itst_in_if  in_if ();
  itst_out_if out_if ();

  interval_timing_stats_table_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin : monitor
    result_t seen;
    if (rst_ni && out_if.valid && out_if.ready) begin
      seen = {out_if.status, out_if.slot, out_if.elapsed, out_if.total_time,
              out_if.begin_count, out_if.min_time, out_if.max_time,
              out_if.unpaired_count, out_if.start_offset, out_if.end_offset};
      sb.check_result(seen);
    end
  end

  task automatic send_event(op_e op, logic [15:0] tag, logic [31:0] ts);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.opcode    <= op;
    in_if.tag       <= tag;
    in_if.timestamp <= ts;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_event(op, tag, ts);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_enable(logic en);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= en;
    @(posedge clk_i);
    sb.enable = en;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_event();
    logic [15:0] tag;
    logic [31:0] ts;
    op_e         op;
    // now and then, hold off until the block has returned everything
    if ($urandom_range(59) == 0) wait_drained();
    tag  = tag_pool[$urandom_range(POOL - 1)];
    tick = tick + $urandom_range(1, 2000);
    if ($urandom_range(49) == 0) tick = $urandom;
    ts = tick;
    if ($urandom_range(99) < 80) begin
      op = sb.tag_open(tag) ? OP_END : OP_BEGIN;
    end else begin
      op = op_e'($urandom_range(1));
      if ($urandom_range(1) == 1) ts = $urandom;
      if (op == OP_END && $urandom_range(2) == 0) tag = 16'($urandom);
    end
    send_event(op, tag, ts);
  endtask

  task automatic run_phase(int idle, int stall, int n);
    idle_pct  = idle;
    stall_pct = stall;
    repeat (n) random_event();
  endtask

  initial begin
    bit dup;
    in_if.valid     = 1'b0;
    in_if.opcode    = 1'b0;
    in_if.tag       = '0;
    in_if.timestamp = '0;
    tag_pool[0] = 16'h8001;
    tag_pool[1] = 16'h0000;
    tag_pool[2] = 16'hFFFF;
    for (int i = 3; i < POOL; i++) begin
      do begin
        tag_pool[i] = 16'($urandom);
        dup = 1'b0;
        for (int j = 0; j < i; j++) if (tag_pool[j] == tag_pool[i]) dup = 1'b1;
      end while (dup);
    end

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_event(OP_BEGIN, 16'hFFFF, 32'hFFFF_FFFF);
    send_event(OP_END, 16'h0000, 32'h0);
    write_enable(1'b0);
    send_event(OP_BEGIN, 16'h8001, 32'd500);
    write_enable(1'b1);
    send_event(OP_END, 16'h1234, 32'd10);
    send_event(OP_BEGIN, 16'h8001, 32'd500);
    send_event(OP_BEGIN, 16'h0000, 32'd0);
    send_event(OP_BEGIN, 16'h0000, 32'd7);
    send_event(OP_END, 16'h0000, 32'd100);
    send_event(OP_END, 16'h0000, 32'd120);
    send_event(OP_BEGIN, 16'h0000, 32'd200);
    send_event(OP_END, 16'h0000, 32'd150);
    send_event(OP_BEGIN, 16'hFFFF, 32'hFFFF_FFFF);
    send_event(OP_END, 16'hFFFF, 32'hFFFF_FFFE);
    send_event(OP_END, 16'h8001, 32'd500);
    send_event(OP_BEGIN, 16'h8001, 32'd1000);
    send_event(OP_END, 16'h8001, 32'h7FFF_FFFF);
    send_event(OP_END, 16'h5555, 32'h8000_0000);

    tick = 32'd1000;
    run_phase(0, 0, 160);
    run_phase(81, 0, 160);
    write_enable(1'b0);
    run_phase(0, 0, 20);
    write_enable(1'b1);
    run_phase(0, 81, 160);
    run_phase(36, 36, 160);

    wait_drained();
    repeat (10) @(negedge clk_i);
    sb.close_out();
    $display("Checked %0d results: %0d ok, %0d disabled, %0d table full, %0d unknown tag, %0d unpaired",
             sb.results_seen, sb.status_seen[ST_OK], sb.status_seen[ST_DISABLED],
             sb.status_seen[ST_FULL], sb.status_seen[ST_NOT_FOUND],
             sb.status_seen[ST_UNPAIRED]);
    $display("Slots allocated %0d of %0d, across idle, stall and enable-off phases",
             sb.slots_used, SLOTS);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results outstanding", sb.pending.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
